### design/mfs_pkg.sv
// shared types and constants for the mingru forward scan block
package mfs_pkg;

	localparam int unsigned IDX_W  = 10;
	localparam int unsigned DATA_W = 16;
	localparam int unsigned NUM_W  = 64;
	localparam int unsigned DEN_W  = 32;
	localparam int unsigned CNT_W  = 7;

	localparam logic [31:0] Q30_ONE = 32'h4000_0000;
	localparam logic [31:0] LN2_Q30 = 32'd744261118;
	localparam logic [15:0] H_MAX   = 16'd16384;

	// floor(2^37 / ln2 in q30): quotient estimate low by at most one
	localparam logic [7:0]  RED_M   = 8'd184;

	// all-ones reciprocal base for the small horner divisors, scaled by 2^33
	localparam logic [32:0] RK_BASE = 33'h1_FFFF_FFFF;

	// numerator bit count of the sigmoid reciprocal division
	localparam logic [CNT_W-1:0] NB_SIG = 7'd61;

	localparam logic [2:0] HORNER_TOP = 3'd6;

	// one classified time step
	typedef struct packed {
		logic [IDX_W-1:0]  sidx;
		logic              first;
		logic              gneg;
		logic [DATA_W-1:0] gabs;
		logic              cneg;
		logic [DATA_W-1:0] cabs;
	} item_t;

	// divider request, numerator left aligned
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [CNT_W-1:0] nb;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quot;
		logic [DEN_W-1:0] rem;
	} div_rsp_t;

endpackage

### design/mingru_forward_scan.sv
// top level of the per-stream mingru recurrence
// Each transaction names a stream and carries one time step's gate and
// candidate pre-activation; one result comes back per transaction with the
// new hidden state. An item occupies the back end through the steps below,
// and longer while the result side keeps a previous result waiting: stream
// index reduction and state read, then for the gate and again for the
// candidate a range reduction by ln2 (estimate, then one correction), six
// Horner steps (multiply, sum, estimate, fix), a step to form 1 + e^-a and a
// 61-bit bit-serial reciprocal division, then the state update (multiply,
// add, output). The front queue holds two further items so the input side
// keeps flowing while the back end works. After reset the state memory is
// swept to zero, during which in_ready stays low.
module mingru_forward_scan #(
	parameter int unsigned STREAMS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [9:0]          stream_index,
	input  logic                first_step,
	input  logic signed [15:0]  gate_pre,
	input  logic signed [15:0]  cand_pre,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [9:0]          stream_echo,
	output logic signed [15:0]  hidden_out
);

	mfs_pkg::item_t    item;
	logic              item_valid;
	logic              item_pop;
	logic              clearing;
	mfs_pkg::div_req_t dreq;
	mfs_pkg::div_rsp_t drsp;

	mfs_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.stream_index (stream_index),
		.first_step   (first_step),
		.gate_pre     (gate_pre),
		.cand_pre     (cand_pre),
		.clearing     (clearing),
		.item_valid   (item_valid),
		.item         (item),
		.item_pop     (item_pop)
	);

	mfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

	mfs_back #(
		.STREAMS (STREAMS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.item_valid  (item_valid),
		.item        (item),
		.item_pop    (item_pop),
		.clearing    (clearing),
		.dreq        (dreq),
		.drsp        (drsp),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.stream_echo (stream_echo),
		.hidden_out  (hidden_out)
	);

endmodule

### design/mfs_front.sv
// front end: accepts time steps, splits sign and magnitude, queues them
module mfs_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [9:0]          stream_index,
	input  logic                first_step,
	input  logic signed [15:0]  gate_pre,
	input  logic signed [15:0]  cand_pre,
	input  logic                clearing,
	output logic                item_valid,
	output mfs_pkg::item_t      item,
	input  logic                item_pop
);

	mfs_pkg::item_t slot_q [2];
	mfs_pkg::item_t cls;
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;
	logic       push;

	// classify the incoming transaction
	always_comb begin
		cls.sidx  = stream_index;
		cls.first = first_step;
		cls.gneg  = gate_pre[15];
		cls.gabs  = gate_pre[15] ? 16'(-gate_pre) : 16'(gate_pre);
		cls.cneg  = cand_pre[15];
		cls.cabs  = cand_pre[15] ? 16'(-cand_pre) : 16'(cand_pre);
	end

	assign in_ready   = (cnt_q != 2'd2) && !clearing;
	assign push       = in_valid && in_ready;
	assign item_valid = (cnt_q != 2'd0);
	assign item       = slot_q[rptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wptr_q] <= cls;
		end
	end

	// queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (item_pop) rptr_q <= ~rptr_q;
			case ({push, item_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### design/mfs_div.sv
// shared restoring divider, one quotient bit per cycle
module mfs_div (
	input  logic               clk,
	input  logic               arst_n,
	input  mfs_pkg::div_req_t  req,
	output mfs_pkg::div_rsp_t  rsp
);

	logic [mfs_pkg::NUM_W-1:0] sh_q;
	logic [mfs_pkg::NUM_W-1:0] quot_q;
	logic [mfs_pkg::DEN_W-1:0] rem_q;
	logic [mfs_pkg::DEN_W-1:0] den_q;
	logic [mfs_pkg::CNT_W-1:0] cnt_q;
	logic                      busy_q;
	logic                      done_q;
	logic [mfs_pkg::DEN_W:0]   trial;
	logic                      fits;

	// one shift-subtract step
	always_comb begin
		trial = {rem_q, sh_q[mfs_pkg::NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q   <= req.num;
			quot_q <= '0;
			rem_q  <= '0;
			den_q  <= req.den;
		end else if (busy_q) begin
			sh_q   <= {sh_q[mfs_pkg::NUM_W-2:0], 1'b0};
			quot_q <= {quot_q[mfs_pkg::NUM_W-2:0], fits};
			rem_q  <= fits ? mfs_pkg::DEN_W'(trial - {1'b0, den_q})
			               : mfs_pkg::DEN_W'(trial);
		end
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (req.start) begin
			cnt_q  <= req.nb;
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			cnt_q  <= cnt_q - 1'b1;
			busy_q <= (cnt_q != 7'd1);
			done_q <= (cnt_q == 7'd1);
		end else begin
			done_q <= 1'b0;
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;
	assign rsp.rem  = rem_q;

endmodule

### design/mfs_back.sv
// back end: sequencer for sigmoid, tanh and state update, plus state memory
module mfs_back #(
	parameter int unsigned STREAMS = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	input  mfs_pkg::item_t      item,
	output logic                item_pop,
	output logic                clearing,
	output mfs_pkg::div_req_t   dreq,
	input  mfs_pkg::div_rsp_t   drsp,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [9:0]          stream_echo,
	output logic signed [15:0]  hidden_out
);

	localparam int unsigned SW = (STREAMS > 1) ? $clog2(STREAMS) : 1;
	// reciprocal of STREAMS scaled by 2^26, quotient estimate low by at most one
	localparam logic [25:0] MOD_M = 26'(((1 << 26) - 1) / STREAMS);

	typedef enum logic [13:0] {
		S_IDLE   = 14'h0001,
		S_MOD    = 14'h0002,
		S_RED1   = 14'h0004,
		S_RED2   = 14'h0008,
		S_MUL    = 14'h0010,
		S_HSUM   = 14'h0020,
		S_HEST   = 14'h0040,
		S_HFIX   = 14'h0080,
		S_EPREP  = 14'h0100,
		S_LAUNCH = 14'h0200,
		S_WAIT   = 14'h0400,
		S_FMUL   = 14'h0800,
		S_FADD   = 14'h1000,
		S_FOUT   = 14'h2000
	} state_t;

	state_t          state_q;
	mfs_pkg::item_t  item_q;
	logic            phase_q;
	logic [SW-1:0]   slot_q;
	logic [9:0]      mq_q;
	logic [36:0]     a_q;
	logic [6:0]      n_q;
	logic [29:0]     r_q;
	logic [30:0]     q_q;
	logic [2:0]      k_q;
	logic [60:0]     prod_q;
	logic [30:0]     x_q;
	logic [30:0]     est_q;
	logic [31:0]     d_q;
	logic [30:0]     z_q;
	logic signed [31:0] c_q;
	logic signed [15:0] hp_q;
	logic signed [63:0] prod2_q;
	logic signed [63:0] tot_q;

	logic [15:0]     mem_q [STREAMS];
	logic [15:0]     rd_q;
	logic            clearing_q;
	logic [SW-1:0]   clr_cnt_q;

	logic            out_valid_q;
	logic [9:0]      echo_q;
	logic signed [15:0] hid_q;

	logic            out_free;
	logic            mem_re;
	logic            mem_we;
	logic [SW-1:0]   mem_wa;
	logic [15:0]     mem_wd;

	logic [35:0]     mest;
	logic [26:0]     mprod;
	logic [26:0]     mrem;
	logic [26:0]     mslot;
	logic [44:0]     nest;
	logic [36:0]     rprod;
	logic [36:0]     rrem;
	logic            rfix;
	logic [61:0]     hsum;
	logic [32:0]     rk;
	logic [63:0]     eprod;
	logic [33:0]     kprod;
	logic [33:0]     krem;
	logic [30:0]     hquot;
	logic [60:0]     sig_num;
	logic [30:0]     s_val;
	logic [31:0]     c_mag;
	logic signed [15:0] hp_sel;
	logic signed [32:0] diff;
	logic [63:0]     mag;
	logic [63:0]     rnd;
	logic [17:0]     qv;
	logic [15:0]     qsat;
	logic signed [15:0] h_new;

	assign out_free = !out_valid_q || out_ready;
	assign item_pop = (state_q == S_IDLE) && item_valid && !clearing_q;
	assign clearing = clearing_q;

	// divider only forms the sigmoid reciprocal
	assign dreq.start = (state_q == S_LAUNCH);
	assign dreq.num   = {sig_num, 3'd0};
	assign dreq.nb    = mfs_pkg::NB_SIG;
	assign dreq.den   = d_q;

	// reciprocal of the current horner divisor, scaled by 2^33
	always_comb begin
		unique case (k_q)
			3'd1:    rk = mfs_pkg::RK_BASE;
			3'd2:    rk = mfs_pkg::RK_BASE / 33'd2;
			3'd3:    rk = mfs_pkg::RK_BASE / 33'd3;
			3'd4:    rk = mfs_pkg::RK_BASE / 33'd4;
			3'd5:    rk = mfs_pkg::RK_BASE / 33'd5;
			3'd6:    rk = mfs_pkg::RK_BASE / 33'd6;
			default: rk = mfs_pkg::RK_BASE;
		endcase
	end

	// datapath pieces used by the sequencer
	always_comb begin
		mest    = 36'(item.sidx) * 36'(MOD_M);
		mprod   = 27'(mq_q) * 27'(STREAMS);
		mrem    = 27'(item_q.sidx) - mprod;
		mslot   = (mrem >= 27'(STREAMS)) ? mrem - 27'(STREAMS) : mrem;
		nest    = 45'(a_q) * 45'(mfs_pkg::RED_M);
		rprod   = 37'(n_q) * 37'(mfs_pkg::LN2_Q30);
		rrem    = a_q - rprod;
		rfix    = rrem >= 37'(mfs_pkg::LN2_Q30);
		hsum    = 62'(prod_q) + (62'(k_q) << 29);
		eprod   = 64'(x_q) * 64'(rk);
		kprod   = 34'(est_q) * 34'(k_q);
		krem    = 34'(x_q) - kprod;
		hquot   = est_q + 31'(krem >= 34'(k_q));
		sig_num = 61'(64'h1000_0000_0000_0000) + 61'(d_q >> 1);
		s_val   = drsp.quot[30:0];
		c_mag   = {s_val, 1'b0} - mfs_pkg::Q30_ONE;
		hp_sel  = item_q.first ? 16'sd0 : $signed(rd_q);
		diff    = 33'(c_q) - (33'(hp_sel) <<< 16);
		mag     = tot_q[63] ? 64'(-tot_q) : 64'(tot_q);
		rnd     = mag + 64'h0000_2000_0000_0000;
		qv      = rnd[63:46];
		qsat    = (qv > 18'(mfs_pkg::H_MAX)) ? mfs_pkg::H_MAX : qv[15:0];
		h_new   = tot_q[63] ? -$signed(qsat) : $signed(qsat);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (item_pop) begin
						item_q  <= item;
						mq_q    <= mest[35:26];
						a_q     <= {1'b0, item.gabs, 20'd0};
						phase_q <= 1'b0;
						state_q <= S_MOD;
					end
				end
				S_MOD: begin
					slot_q  <= mslot[SW-1:0];
					state_q <= S_RED1;
				end
				// range reduction by ln2, estimate then one correction
				S_RED1: begin
					n_q     <= nest[43:37];
					state_q <= S_RED2;
				end
				S_RED2: begin
					r_q     <= rfix ? 30'(rrem - 37'(mfs_pkg::LN2_Q30)) : rrem[29:0];
					n_q     <= n_q + 7'(rfix);
					q_q     <= mfs_pkg::Q30_ONE[30:0];
					k_q     <= mfs_pkg::HORNER_TOP;
					state_q <= S_MUL;
				end
				// one horner step: multiply, sum, estimate, fix
				S_MUL: begin
					prod_q  <= 61'(r_q) * 61'(q_q);
					state_q <= S_HSUM;
				end
				S_HSUM: begin
					x_q     <= hsum[60:30];
					state_q <= S_HEST;
				end
				S_HEST: begin
					est_q   <= eprod[63:33];
					state_q <= S_HFIX;
				end
				S_HFIX: begin
					q_q <= mfs_pkg::Q30_ONE[30:0] - hquot;
					if (k_q == 3'd1) begin
						state_q <= S_EPREP;
					end else begin
						k_q     <= k_q - 3'd1;
						state_q <= S_MUL;
					end
				end
				S_EPREP: begin
					d_q     <= mfs_pkg::Q30_ONE + (n_q[6] ? 32'd0 : 32'(q_q >> n_q[5:0]));
					state_q <= S_LAUNCH;
				end
				S_LAUNCH: state_q <= S_WAIT;
				S_WAIT: begin
					if (drsp.done) begin
						if (!phase_q) begin
							z_q     <= item_q.gneg ? mfs_pkg::Q30_ONE[30:0] - s_val
							                       : s_val;
							phase_q <= 1'b1;
							a_q     <= {item_q.cabs, 21'd0};
							state_q <= S_RED1;
						end else begin
							c_q     <= item_q.cneg ? -$signed(c_mag) : $signed(c_mag);
							state_q <= S_FMUL;
						end
					end
				end
				S_FMUL: begin
					hp_q    <= hp_sel;
					prod2_q <= 64'($signed({1'b0, z_q}) * diff);
					state_q <= S_FADD;
				end
				S_FADD: begin
					tot_q   <= (64'(hp_q) <<< 46) + prod2_q;
					state_q <= S_FOUT;
				end
				S_FOUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// state memory port control
	assign mem_re = (state_q == S_MOD);
	assign mem_we = clearing_q || ((state_q == S_FOUT) && out_free);
	assign mem_wa = clearing_q ? clr_cnt_q : slot_q;
	assign mem_wd = clearing_q ? 16'd0 : 16'(h_new);

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
		if (mem_re) rd_q <= mem_q[mslot[SW-1:0]];
	end

	// clearing pass after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_cnt_q  <= '0;
		end else if (clearing_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == SW'(STREAMS - 1)) clearing_q <= 1'b0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == S_FOUT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_FOUT) && out_free) begin
			echo_q <= item_q.sidx;
			hid_q  <= h_new;
		end
	end

	assign out_valid   = out_valid_q;
	assign stream_echo = echo_q;
	assign hidden_out  = hid_q;

endmodule

### design/mfs_checker.sv
// port-level checks for the mingru forward scan, bound to the top level
module mfs_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [9:0]         stream_echo,
	input logic signed [15:0] hidden_out
);

	logic [3:0] pend_q;

	// transactions accepted but not yet delivered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			case ({in_valid && in_ready, out_valid && out_ready})
				2'b10:   pend_q <= pend_q + 4'd1;
				2'b01:   pend_q <= pend_q - 4'd1;
				default: pend_q <= pend_q;
			endcase
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(hidden_out) && $stable(stream_echo))
		else $error("result changed while stalled");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (hidden_out <= 16'sd16384) && (hidden_out >= -16'sd16384))
		else $error("hidden state out of range");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> pend_q != 4'd0)
		else $error("result with no pending transaction");

	a_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q <= 4'd4)
		else $error("more transactions in flight than storage");

endmodule

bind mingru_forward_scan mfs_checker u_chk (.*);

### verif/mingru_forward_scan_checker.sv
// checker for the mingru forward scan: predicts hidden states and compares results
module mingru_forward_scan_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [9:0]         stream_index,
	input  logic               first_step,
	input  logic signed [15:0] gate_pre,
	input  logic signed [15:0] cand_pre,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic [9:0]         stream_echo,
	input  logic signed [15:0] hidden_out,
	output int                 err_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STREAMS = 1024;
	localparam logic [63:0] ONE_Q30 = 64'h4000_0000;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;

	typedef struct {
		logic [9:0]         sidx;
		logic signed [15:0] h;
	} hidden_result_t;

	logic signed [15:0] hidden_mem [STREAMS];
	hidden_result_t     hidden_q [$];

	// exp(-a) in Q30 by range reduction and Horner over the Taylor series
	function automatic logic [63:0] exp_neg(input logic [63:0] a);
		logic [63:0] n, r, q, d;
		n = a / LN2_Q30;
		r = a - n * LN2_Q30;
		q = ONE_Q30;
		for (int k = 6; k >= 1; k--) begin
			d = 64'(k) * ONE_Q30;
			q = ONE_Q30 - (r * q + d / 2) / d;
		end
		if (n >= 64)
			return 64'd0;
		return q >> n;
	endfunction

	// logistic of a non-negative Q30 argument
	function automatic logic [63:0] sigmoid_pos(input logic [63:0] a);
		logic [63:0] d;
		d = ONE_Q30 + exp_neg(a);
		return ((64'd1 << 60) + d / 2) / d;
	endfunction

	// one recurrence step: new hidden value from previous state and pre-activations
	function automatic logic signed [15:0] scan_step(input logic signed [15:0] hprev,
			input logic signed [15:0] g, input logic signed [15:0] v);
		logic [63:0] ga, va, s, mag, q;
		longint      z, c, hp, total;
		ga = (g < 0) ? 64'(-32'(g)) : 64'(g);
		va = (v < 0) ? 64'(-32'(v)) : 64'(v);
		s = sigmoid_pos(ga << 20);
		z = (g < 0) ? longint'(ONE_Q30 - s) : longint'(s);
		s = sigmoid_pos(va << 21);
		c = longint'(2 * s) - longint'(ONE_Q30);
		if (v < 0)
			c = -c;
		hp = longint'(hprev);
		total = hp * (longint'(1) << 46) + z * (c - hp * 65536);
		mag = (total < 0) ? 64'(-total) : 64'(total);
		q = (mag + (64'd1 << 45)) >> 46;
		if (q > 64'd16384)
			q = 64'd16384;
		return (total < 0) ? -16'(q) : 16'(q);
	endfunction

	assign pending = hidden_q.size();

	// predict on input transaction, compare on output transaction
	always @(posedge clk or negedge arst_n) begin
		hidden_result_t     exp_r;
		logic signed [15:0] hprev;
		if (!arst_n) begin
			err_count = 0;
			hidden_q.delete();
			for (int i = 0; i < STREAMS; i++)
				hidden_mem[i] = '0;
		end else begin
			if (in_valid && in_ready) begin
				hprev = first_step ? 16'sd0 : hidden_mem[stream_index % STREAMS];
				exp_r.sidx = stream_index;
				exp_r.h = scan_step(hprev, gate_pre, cand_pre);
				hidden_mem[stream_index % STREAMS] = exp_r.h;
				hidden_q.push_back(exp_r);
			end
			if (out_valid && out_ready) begin
				if (hidden_q.size() == 0) begin
					$display("%0t: unexpected result stream %0d hidden %0d", $time,
						stream_echo, hidden_out);
					err_count++;
				end else begin
					exp_r = hidden_q.pop_front();
					if (stream_echo !== exp_r.sidx) begin
						$display("%0t: stream_echo expected %0d actual %0d", $time,
							exp_r.sidx, stream_echo);
						err_count++;
					end
					if (hidden_out !== exp_r.h) begin
						$display("%0t: hidden_out expected %0d actual %0d", $time,
							exp_r.h, hidden_out);
						err_count++;
					end
				end
			end
		end
	end
endmodule

### verif/mingru_forward_scan_tb.sv
// testbench top for the mingru forward scan: stimulus, flow control and verdict
module mingru_forward_scan_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1830;
	localparam int IDLE_LIMIT   = 20000;
	localparam int DRAIN_CYCLES = 800;
	localparam int HOLD_CYCLES  = 3000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [9:0]         stream_index = '0;
	logic               first_step = 1'b0;
	logic signed [15:0] gate_pre = '0;
	logic signed [15:0] cand_pre = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [9:0]         stream_echo;
	logic signed [15:0] hidden_out;
	int                 err_count;
	int                 pending;
	logic               steady = 1'b0;
	logic               hold_req = 1'b0;
	int                 idle_cycles = 0;

	mingru_forward_scan u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.stream_index(stream_index), .first_step(first_step),
		.gate_pre(gate_pre), .cand_pre(cand_pre),
		.out_valid(out_valid), .out_ready(out_ready),
		.stream_echo(stream_echo), .hidden_out(hidden_out)
	);

	mingru_forward_scan_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.stream_index(stream_index), .first_step(first_step),
		.gate_pre(gate_pre), .cand_pre(cand_pre),
		.out_valid(out_valid), .out_ready(out_ready),
		.stream_echo(stream_echo), .hidden_out(hidden_out),
		.err_count(err_count), .pending(pending)
	);

	always #5 clk = ~clk;

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = steady ? 0 : $urandom_range(0, 19);
			if (hold_req)
				gap = HOLD_CYCLES;
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// offer one time step and wait until it is taken
	task automatic send_step(input logic [9:0] idx, input logic first,
			input logic [15:0] g, input logic [15:0] v);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		stream_index <= idx;
		first_step <= first;
		gate_pre <= g;
		cand_pre <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	// pre-activation with a spread of magnitudes: near zero, mid range, full range
	function automatic logic [15:0] pick_pre();
		case ($urandom_range(0, 3))
			0: return 16'($signed($urandom_range(0, 255)) - 128);
			1: return 16'($signed($urandom_range(0, 8191)) - 4096);
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [9:0] pool [8];
		logic [9:0] idx;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes of both pre-activations, first-step and continuation
		send_step(10'd0, 1'b1, 16'h0000, 16'h0000);
		send_step(10'd0, 1'b0, 16'h7fff, 16'h7fff);
		send_step(10'd0, 1'b0, 16'h7fff, 16'h8000);
		send_step(10'd0, 1'b0, 16'h8000, 16'h7fff);
		send_step(10'd0, 1'b0, 16'h0001, 16'hffff);
		send_step(10'd1023, 1'b1, 16'h7fff, 16'h7fff);
		send_step(10'd1023, 1'b0, 16'h8000, 16'h8000);
		send_step(10'd1023, 1'b0, 16'h0400, 16'hfc00);
		send_step(10'd1023, 1'b1, 16'hffff, 16'h0001);
		send_step(10'd512, 1'b0, 16'h0000, 16'h7fff);
		send_step(10'd512, 1'b0, 16'h7fff, 16'h0000);
		send_step(10'd512, 1'b1, 16'h8000, 16'h0000);
		send_step(10'd341, 1'b0, 16'h5555, 16'haaaa);
		send_step(10'd682, 1'b0, 16'haaaa, 16'h5555);
		send_step(10'd341, 1'b0, 16'h2000, 16'he000);

		// random: short sequences over a small stream pool, some scattered streams
		for (int i = 0; i < 8; i++)
			pool[i] = 10'($urandom);
		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 200 == 100) begin
				steady <= ($urandom_range(0, 2) == 0);
			end
			// request window over a few items so the result side surely sees it
			hold_req <= (i >= 400) && (i < 404);
			idx = ($urandom_range(0, 4) == 0) ? 10'($urandom) : pool[$urandom_range(0, 7)];
			send_step(idx, $urandom_range(0, 5) == 0, pick_pre(), pick_pre());
		end
		in_valid <= 1'b0;
		steady <= 1'b0;

		// drain and verdict
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

### mingru_forward_scan.f
design/mfs_pkg.sv
design/mfs_front.sv
design/mfs_div.sv
design/mfs_back.sv
design/mingru_forward_scan.sv
design/mfs_checker.sv
verif/mingru_forward_scan_checker.sv
verif/mingru_forward_scan_tb.sv
